/* rtl/core/otb_pkg.sv */
// Shared types, widths and codes of the overwriting tail buffer.
package otb_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 4096;
   localparam int unsigned MAX_READ_DEFAULT = 64;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 64;
   localparam int unsigned LIMIT_W  = 7;

   // Request opcodes. The fourth code is ignored by the block.
   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   // Operations of the shared adder.
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [OFFSET_W-1:0] a;
      logic [OFFSET_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] sum;
      logic                borrow;
   } alu_rsp_type;

endpackage

/* rtl/core/otb_if.sv */
// Request and response channel interfaces of the overwriting tail buffer.
interface otb_req_if import otb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   data_byte;
   logic                end_of_chunk;
   logic [OFFSET_W-1:0] read_offset;
   logic [LIMIT_W-1:0]  read_limit;

   modport source (output valid, opcode, data_byte, end_of_chunk, read_offset, read_limit,
                   input ready);
   modport sink (input valid, opcode, data_byte, end_of_chunk, read_offset, read_limit,
                 output ready);
endinterface

interface otb_rsp_if import otb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [OFFSET_W-1:0] byte_offset;
   logic                has_data;
   logic                last;

   modport source (output valid, out_byte, byte_offset, has_data, last, input ready);
   modport sink (input valid, out_byte, byte_offset, has_data, last, output ready);
endinterface

/* rtl/core/overwriting_tail_buffer.sv */
// Top level of the overwriting tail buffer: sequencer, state and response register.
//
// Keeps the most recent CAPACITY bytes of a byte stream and counts every byte
// appended since reset or the last clear (64-bit, wrapping). Requests arrive on req_ch,
// results leave on rsp_ch; both use valid/ready and move at an edge where both are high.
// An append request writes its byte in the append step after acceptance; a clear
// or an unused opcode completes at acceptance. A read request runs six setup
// steps on the shared 64-bit adder (oldest offset, start clamp, end check,
// count, store position, position wrap), then for each byte a store read
// step and a load step that loads the response register and advances the
// offset on the adder. An empty read delivers its single result from the
// empty step that follows the end check.
// req_ch.ready is high only while the sequencer is idle; the last response of
// a read may still wait in the output register while the next request is
// taken. When the receiver stalls, the sequencer holds in its load step and
// the store read data holds with it. Reset clears the counters, pointers and
// the response valid; the store contents are never read before being written.
module overwriting_tail_buffer import otb_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT,
   parameter int unsigned MAX_READ = MAX_READ_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   otb_req_if.sink    req_ch,
   otb_rsp_if.source  rsp_ch
);

   localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned POS_W  = IDX_W + 1;
   localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
   localparam int unsigned LIM_W  = $clog2(MAX_READ + 1);
   localparam int unsigned CNT_W  = (FILL_W > LIM_W) ? FILL_W : LIM_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_R_FIRST,
      ST_R_LOW,
      ST_R_HIGH,
      ST_R_COUNT,
      ST_R_POS,
      ST_R_WRAP,
      ST_R_READ,
      ST_R_LOAD,
      ST_R_EMPTY
   } state_type;

   state_type           state_ff, state_in;
   logic [OFFSET_W-1:0] total_ff, total_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]    oldest_ff, oldest_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [OFFSET_W-1:0] first_ff, first_in;
   logic [FILL_W-1:0]   local_ff, local_in;
   logic [LIM_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                rsp_has_data_ff, rsp_has_data_in;
   logic                rsp_last_ff, rsp_last_in;

   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;
   logic                wr_en;
   logic                rd_en;
   logic [BYTE_W-1:0]   rd_data;
   logic                out_free;
   logic                req_fire;
   logic                store_full;
   logic [LIM_W-1:0]    limit_sat;

   otb_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   otb_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (head_ff),
      .wr_data (data_ff),
      .rd_en   (rd_en),
      .rd_idx  (pos_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign store_full   = (fill_ff == FILL_W'(CAPACITY));
   assign wr_en        = (state_ff == ST_APPEND);
   assign rd_en        = (state_ff == ST_R_READ);

   // Read limits above the largest read saturate.
   assign limit_sat = (req_ch.read_limit > LIMIT_W'(MAX_READ)) ? LIM_W'(MAX_READ)
                                                              : LIM_W'(req_ch.read_limit);

   // Sequencer: each step drives the shared adder once and updates the state.
   always_comb begin
      state_in        = state_ff;
      total_in        = total_ff;
      fill_in         = fill_ff;
      oldest_in       = oldest_ff;
      head_in         = head_ff;
      data_in         = data_ff;
      offset_in       = offset_ff;
      first_in        = first_ff;
      local_in        = local_ff;
      limit_in        = limit_ff;
      cnt_in          = cnt_ff;
      pos_in          = pos_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ch.ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_has_data_in = rsp_has_data_ff;
      rsp_last_in     = rsp_last_ff;
      alu_req.op      = ALU_ADD;
      alu_req.a       = total_ff;
      alu_req.b       = OFFSET_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.opcode)
                  OP_APPEND: begin
                     data_in  = req_ch.data_byte;
                     state_in = ST_APPEND;
                  end
                  OP_READ: begin
                     offset_in = req_ch.read_offset;
                     limit_in  = limit_sat;
                     state_in  = ST_R_FIRST;
                  end
                  OP_CLEAR: begin
                     total_in  = '0;
                     fill_in   = '0;
                     oldest_in = '0;
                     head_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // The byte goes in at the head; a full store drops its oldest byte.
         ST_APPEND: begin
            total_in = alu_rsp.sum;
            head_in  = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);
            if (store_full) begin
               oldest_in = (oldest_ff == IDX_W'(CAPACITY - 1)) ? '0 : oldest_ff + IDX_W'(1);
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = ST_IDLE;
         end

         // Offset of the oldest held byte.
         ST_R_FIRST: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = total_ff;
            alu_req.b  = OFFSET_W'(fill_ff);
            first_in   = alu_rsp.sum;
            state_in   = ST_R_LOW;
         end

         // A start before the oldest byte moves up to it.
         ST_R_LOW: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = offset_ff;
            alu_req.b  = first_ff;
            if (alu_rsp.borrow) begin
               offset_in = first_ff;
               local_in  = '0;
            end else begin
               local_in = alu_rsp.sum[FILL_W-1:0];
            end
            state_in = ST_R_HIGH;
         end

         // A start past the newest byte, or a zero limit, gives an empty read.
         ST_R_HIGH: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = offset_ff;
            alu_req.b  = total_ff;
            if (!alu_rsp.borrow || (limit_ff == '0)) begin
               state_in = ST_R_EMPTY;
            end else begin
               state_in = ST_R_COUNT;
            end
         end

         // Bytes held from the start onward.
         ST_R_COUNT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = OFFSET_W'(fill_ff);
            alu_req.b  = OFFSET_W'(local_ff);
            cnt_in     = CNT_W'(alu_rsp.sum[FILL_W-1:0]);
            state_in   = ST_R_POS;
         end

         // Unwrapped store position of the first byte; clip the count to the limit.
         ST_R_POS: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = OFFSET_W'(oldest_ff);
            alu_req.b  = OFFSET_W'(local_ff);
            pos_in     = alu_rsp.sum[POS_W-1:0];
            if (cnt_ff > CNT_W'(limit_ff)) begin
               cnt_in = CNT_W'(limit_ff);
            end
            state_in = ST_R_WRAP;
         end

         // The position stays below twice the capacity, so one subtraction wraps it.
         ST_R_WRAP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = OFFSET_W'(pos_ff);
            alu_req.b  = OFFSET_W'(CAPACITY);
            if (!alu_rsp.borrow) begin
               pos_in = alu_rsp.sum[POS_W-1:0];
            end
            state_in = ST_R_READ;
         end

         ST_R_READ: begin
            state_in = ST_R_LOAD;
         end

         // Load one byte into the response register and step to the next one.
         ST_R_LOAD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = offset_ff;
            alu_req.b  = OFFSET_W'(1);
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_byte_in     = rd_data;
               rsp_offset_in   = offset_ff;
               rsp_has_data_in = 1'b1;
               rsp_last_in     = (cnt_ff == CNT_W'(1));
               offset_in       = alu_rsp.sum;
               cnt_in          = cnt_ff - CNT_W'(1);
               if (pos_ff[IDX_W-1:0] == IDX_W'(CAPACITY - 1)) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_R_READ;
            end
         end

         ST_R_EMPTY: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_byte_in     = '0;
               rsp_offset_in   = '0;
               rsp_has_data_in = 1'b0;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff         <= data_in;
      offset_ff       <= offset_in;
      first_ff        <= first_in;
      local_ff        <= local_in;
      limit_ff        <= limit_in;
      cnt_ff          <= cnt_in;
      pos_ff          <= pos_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_has_data_ff <= rsp_has_data_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = rsp_byte_ff;
   assign rsp_ch.byte_offset = rsp_offset_ff;
   assign rsp_ch.has_data    = rsp_has_data_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // The store never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count exceeds capacity");

   // The head always sits fill bytes past the oldest byte, modulo the capacity.
   assert property (@(posedge clock) disable iff (reset)
      ((32'(oldest_ff) + 32'(fill_ff)) == 32'(head_ff)) ||
      ((32'(oldest_ff) + 32'(fill_ff)) == (32'(head_ff) + 32'(CAPACITY))))
      else $error("head pointer out of step with oldest pointer and fill count");

   // Every append advances the byte counter by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND) |=> (total_ff == $past(total_ff) + OFFSET_W'(1)))
      else $error("append did not advance the byte counter");

   // A byte is only loaded while the remaining count is between one and the largest read, MAX_READ.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_LOAD) |-> ((cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_READ))))
      else $error("remaining byte count out of range");

   // An empty result is always the final result of its read.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_data_ff) |-> rsp_last_ff)
      else $error("empty result without last");

endmodule

/* rtl/core/otb_alu.sv */
// Shared 64-bit adder/subtractor for append, read setup and load steps.
module otb_alu import otb_pkg::*; (
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic                sub;
   logic [OFFSET_W-1:0] b_operand;
   logic [OFFSET_W:0]   full_sum;

   // Subtraction adds the complement plus one; a missing carry is a borrow.
   assign sub       = (alu_req.op == ALU_SUB);
   assign b_operand = sub ? ~alu_req.b : alu_req.b;
   assign full_sum  = {1'b0, alu_req.a} + {1'b0, b_operand} + (OFFSET_W + 1)'(sub);

   assign alu_rsp.sum    = full_sum[OFFSET_W-1:0];
   assign alu_rsp.borrow = sub & ~full_sum[OFFSET_W];

endmodule

/* rtl/core/otb_store.sv */
// Byte store: one write port and one registered read port.
module otb_store import otb_pkg::*; #(
   parameter int unsigned DEPTH = CAPACITY_DEFAULT,
   parameter int unsigned IDX_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // The read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the overwriting tail buffer: directed table, random stream, scoreboard.
module testbench;
   import otb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY = CAPACITY_DEFAULT;
   localparam int unsigned MAX_READ = MAX_READ_DEFAULT;

   // The fourth opcode has no enum member; the block ignores it.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int unsigned DRAIN_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   data_byte;
      logic                end_of_chunk;
      logic [OFFSET_W-1:0] read_offset;
      logic [LIMIT_W-1:0]  read_limit;
   } tail_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                has_data;
      logic                last;
   } tail_rsp_type;

   // One directed request; reads with an obvious answer carry it in fixed_rsp.
   typedef struct packed {
      tail_req_type req;
      logic         fixed;
      tail_rsp_type fixed_rsp;
   } directed_row_type;

   localparam tail_rsp_type EMPTY_RSP = '{8'h00, 64'd0, 1'b0, 1'b1};
   localparam tail_rsp_type NO_RSP    = '{8'h00, 64'd0, 1'b0, 1'b0};
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int unsigned DIRECTED_COUNT = 22;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Reads of an empty store after reset, at both ends of the offset range.
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd1},   1'b1, EMPTY_RSP},
      '{'{OP_READ,   8'hFF, 1'b1, OFFSET_MAX, 7'd127}, 1'b1, EMPTY_RSP},
      '{'{OP_CLEAR,  8'h00, 1'b0, 64'd0,      7'd0},   1'b0, NO_RSP},
      '{'{OP_UNUSED, 8'hFF, 1'b1, OFFSET_MAX, 7'd127}, 1'b0, NO_RSP},
      '{'{OP_APPEND, 8'h00, 1'b0, 64'd0,      7'd0},   1'b0, NO_RSP},
      '{'{OP_APPEND, 8'hFF, 1'b0, OFFSET_MAX, 7'd127}, 1'b0, NO_RSP},
      '{'{OP_APPEND, 8'hA5, 1'b1, 64'd0,      7'd0},   1'b0, NO_RSP},
      // A zero limit gives the empty result even with data held.
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd0},   1'b1, EMPTY_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd1},   1'b1, '{8'h00, 64'd0, 1'b1, 1'b1}},
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd127}, 1'b0, NO_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'd2,      7'd64},  1'b1, '{8'hA5, 64'd2, 1'b1, 1'b1}},
      // Start at or past the byte count gives the empty result.
      '{'{OP_READ,   8'h00, 1'b0, 64'd3,      7'd10},  1'b1, EMPTY_RSP},
      '{'{OP_READ,   8'h00, 1'b0, OFFSET_MAX, 7'd64},  1'b1, EMPTY_RSP},
      '{'{OP_UNUSED, 8'h5A, 1'b0, 64'd0,      7'd1},   1'b0, NO_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'd1,      7'd65},  1'b0, NO_RSP},
      '{'{OP_APPEND, 8'h5A, 1'b1, 64'd1,      7'd64},  1'b0, NO_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'h8000_0000_0000_0000, 7'd1}, 1'b1, EMPTY_RSP},
      '{'{OP_CLEAR,  8'hFF, 1'b1, OFFSET_MAX, 7'd127}, 1'b0, NO_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd64},  1'b1, EMPTY_RSP},
      '{'{OP_APPEND, 8'h3C, 1'b1, 64'd0,      7'd0},   1'b0, NO_RSP},
      '{'{OP_READ,   8'h00, 1'b0, 64'd0,      7'd64},  1'b1, '{8'h3C, 64'd0, 1'b1, 1'b1}},
      '{'{OP_READ,   8'h00, 1'b0, 64'd1,      7'd64},  1'b1, EMPTY_RSP}
   };

   logic clock;
   logic reset;

   otb_req_if req_bus ();
   otb_rsp_if rsp_bus ();

   overwriting_tail_buffer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Predicted state of the tail buffer.
   logic [BYTE_W-1:0]   held_bytes [CAPACITY];
   int unsigned         oldest_pos = 0;
   int unsigned         held_count = 0;
   logic [OFFSET_W-1:0] appended_total = '0;

   tail_rsp_type read_results_due [$];
   int unsigned  error_count = 0;
   int unsigned  burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Applies one accepted request to the predicted state and queues its results.
   function automatic void tail_model_apply(tail_req_type req);
      logic [OFFSET_W-1:0] first_offset;
      logic [OFFSET_W-1:0] start;
      logic [OFFSET_W-1:0] skip;
      int unsigned         limit;
      int unsigned         count;
      tail_rsp_type        rsp;
      case (req.opcode)
         OP_APPEND: begin
            appended_total = appended_total + 64'd1;
            if (held_count >= CAPACITY) begin
               oldest_pos = (oldest_pos + 1) % CAPACITY;
               held_count = held_count - 1;
            end
            held_bytes[(oldest_pos + held_count) % CAPACITY] = req.data_byte;
            held_count = held_count + 1;
         end
         OP_READ: begin
            limit = (int'(req.read_limit) > MAX_READ) ? MAX_READ : int'(req.read_limit);
            first_offset = appended_total - 64'(held_count);
            start = (req.read_offset < first_offset) ? first_offset : req.read_offset;
            if (start >= appended_total || limit == 0) begin
               read_results_due.push_back(EMPTY_RSP);
            end else begin
               skip = start - first_offset;
               count = held_count - int'(skip[31:0]);
               if (count > limit) begin
                  count = limit;
               end
               for (int unsigned i = 0; i < count; i++) begin
                  rsp.out_byte = held_bytes[(oldest_pos + int'(skip[31:0]) + i) % CAPACITY];
                  rsp.byte_offset = start + 64'(i);
                  rsp.has_data = 1'b1;
                  rsp.last = (i + 1 == count);
                  read_results_due.push_back(rsp);
               end
            end
         end
         OP_CLEAR: begin
            oldest_pos = 0;
            held_count = 0;
            appended_total = '0;
         end
         default: begin
         end
      endcase
   endfunction

   // Read start: mostly inside or around the held window, sometimes anywhere.
   function automatic logic [OFFSET_W-1:0] pick_read_offset();
      logic [OFFSET_W-1:0] first_offset;
      first_offset = appended_total - 64'(held_count);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return first_offset + 64'($urandom_range(0, held_count + 2));
         4, 5:       return appended_total - 64'($urandom_range(1, 70));
         6:          return first_offset - 64'($urandom_range(1, 8));
         7:          return '0;
         8:          return {$urandom, $urandom};
         default:    return OFFSET_MAX;
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_read_limit();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 7'($urandom_range(MAX_READ + 1, 127));
         default: return 7'($urandom_range(1, MAX_READ));
      endcase
   endfunction

   // Random request; the fields that an opcode ignores carry noise.
   function automatic tail_req_type random_request(bit allow_clear);
      tail_req_type req;
      int unsigned  roll;
      req.data_byte = 8'($urandom);
      req.end_of_chunk = 1'($urandom);
      req.read_offset = {$urandom, $urandom};
      req.read_limit = 7'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         req.opcode = OP_APPEND;
      end else if (roll < 88) begin
         req.opcode = OP_READ;
         req.read_offset = pick_read_offset();
         req.read_limit = pick_read_limit();
      end else if (roll < 95) begin
         req.opcode = OP_UNUSED;
      end else begin
         req.opcode = allow_clear ? OP_CLEAR : OP_APPEND;
      end
      return req;
   endfunction

   // Idle cycles before a request: mostly none or few, a few long, some bursts.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end else if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   // Presents one request at the falling edge and holds it until accepted.
   task automatic send_request(tail_req_type req);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.opcode = req.opcode;
      req_bus.data_byte = req.data_byte;
      req_bus.end_of_chunk = req.end_of_chunk;
      req_bus.read_offset = req.read_offset;
      req_bus.read_limit = req.read_limit;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Response back-pressure: runs of ready broken by stalls of random length.
   initial begin
      int unsigned run_left;
      int unsigned stall_left;
      int unsigned roll;
      run_left = 0;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left == 0 && stall_left == 0) begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               stall_left = 1;
            end else if (roll < 85) begin
               stall_left = $urandom_range(2, 4);
            end else if (roll < 95) begin
               stall_left = $urandom_range(5, 12);
            end else begin
               stall_left = $urandom_range(20, 60);
            end
         end
         if (run_left > 0) begin
            rsp_bus.ready = 1'b1;
            run_left = run_left - 1;
         end else begin
            rsp_bus.ready = 1'b0;
            stall_left = stall_left - 1;
         end
      end
   end

   // Scoreboard: each accepted response against the oldest prediction.
   always @(posedge clock) begin
      tail_rsp_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (read_results_due.size() == 0) begin
            $display("%0t: unexpected response byte %02h offset %0h has_data %0b last %0b",
                     $time, rsp_bus.out_byte, rsp_bus.byte_offset, rsp_bus.has_data,
                     rsp_bus.last);
            error_count++;
         end else begin
            due = read_results_due.pop_front();
            if (rsp_bus.out_byte !== due.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, due.out_byte, rsp_bus.out_byte);
               error_count++;
            end
            if (rsp_bus.byte_offset !== due.byte_offset) begin
               $display("%0t: byte_offset expected %0h actual %0h",
                        $time, due.byte_offset, rsp_bus.byte_offset);
               error_count++;
            end
            if (rsp_bus.has_data !== due.has_data) begin
               $display("%0t: has_data expected %0b actual %0b",
                        $time, due.has_data, rsp_bus.has_data);
               error_count++;
            end
            if (rsp_bus.last !== due.last) begin
               $display("%0t: last expected %0b actual %0b", $time, due.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // Stimulus: directed table, short random streams, a long append run, mixed requests, a clear.
   initial begin
      tail_req_type req;
      int unsigned  waited;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_APPEND;
      req_bus.data_byte = '0;
      req_bus.end_of_chunk = 1'b0;
      req_bus.read_offset = '0;
      req_bus.read_limit = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req);
         if (directed_rows[i].fixed) begin
            read_results_due.push_back(directed_rows[i].fixed_rsp);
         end else begin
            tail_model_apply(directed_rows[i].req);
         end
      end

      // Short streams with frequent clears.
      repeat (110) begin
         req = random_request(1'b1);
         send_request(req);
         tail_model_apply(req);
      end

      // Grow the held window well past the size of one read.
      repeat (100) begin
         req = random_request(1'b0);
         req.opcode = OP_APPEND;
         send_request(req);
         tail_model_apply(req);
      end

      // Mixed requests across the grown window; reads include starts past the newest byte.
      repeat (76) begin
         req = random_request(1'b0);
         send_request(req);
         tail_model_apply(req);
      end

      // Clear a store that holds data and read it back empty.
      req = '{OP_CLEAR, 8'h00, 1'b0, 64'd0, 7'd0};
      send_request(req);
      tail_model_apply(req);
      req = '{OP_READ, 8'h00, 1'b0, 64'd0, 7'd64};
      send_request(req);
      tail_model_apply(req);

      @(negedge clock);
      req_bus.valid = 1'b0;

      waited = 0;
      while (read_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (read_results_due.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, read_results_due.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/otb_pkg.sv
rtl/core/otb_if.sv
rtl/core/otb_alu.sv
rtl/core/otb_store.sv
rtl/core/overwriting_tail_buffer.sv
tb/sv/testbench.sv
